[rtl/trme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_pkg
// Shared types, codes and the microcode table of the register machine
// execute block.
// ----------------------------------------------------------------------------
package trme_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned IMM_W     = 31;
   localparam int unsigned REG_IDX_W = 4;
   localparam int unsigned ACTION_W  = 5;
   localparam int unsigned TARGET_W  = 10;
   localparam int unsigned ERR_W     = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NOP   = 5'd0,
      ACT_MOV   = 5'd1,
      ACT_ADD   = 5'd2,
      ACT_SUB   = 5'd3,
      ACT_AND   = 5'd4,
      ACT_OR    = 5'd5,
      ACT_DIV   = 5'd6,
      ACT_MUL   = 5'd7,
      ACT_INC   = 5'd8,
      ACT_DEC   = 5'd9,
      ACT_PRINT = 5'd10,
      ACT_CMP   = 5'd11,
      ACT_JMP   = 5'd12,
      ACT_JE    = 5'd13,
      ACT_JNE   = 5'd14,
      ACT_JG    = 5'd15,
      ACT_JGE   = 5'd16,
      ACT_JL    = 5'd17,
      ACT_JLE   = 5'd18
   } action_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE         = 2'd0,
      ERR_ABSENT_ARITH = 2'd1,
      ERR_ABSENT_PRINT = 2'd2,
      ERR_DIV_ZERO     = 2'd3
   } error_type;

   // Datapath operation selected by one control word
   typedef enum logic [2:0] {
      UOP_ACCEPT,
      UOP_READ,
      UOP_EXEC,
      UOP_NONE,
      UOP_MUL_WB,
      UOP_DIV_STEP,
      UOP_DIV_WB,
      UOP_RESPOND
   } uop_type;

   typedef enum logic [2:0] {
      JC_NEVER,
      JC_NO_REQ,
      JC_TO_DIV,
      JC_NOT_MUL,
      JC_DIV_MORE,
      JC_OUT_BUSY
   } jump_cond_type;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_READ,
      STEP_EXEC,
      STEP_MUL_CHECK,
      STEP_MUL_WB,
      STEP_DIV_ITER,
      STEP_DIV_WB,
      STEP_RESPOND
   } step_type;

   typedef struct packed {
      uop_type       uop;
      jump_cond_type cond;
      step_type      jump_to;
      step_type      next;
   } ucode_type;

   // Microprogram: branch to jump_to when cond holds, else go to next
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type word;
      case (step)
         STEP_IDLE:      word = '{UOP_ACCEPT,   JC_NO_REQ,   STEP_IDLE,     STEP_READ};
         STEP_READ:      word = '{UOP_READ,     JC_NEVER,    STEP_IDLE,     STEP_EXEC};
         STEP_EXEC:      word = '{UOP_EXEC,     JC_TO_DIV,   STEP_DIV_ITER, STEP_MUL_CHECK};
         STEP_MUL_CHECK: word = '{UOP_NONE,     JC_NOT_MUL,  STEP_RESPOND,  STEP_MUL_WB};
         STEP_MUL_WB:    word = '{UOP_MUL_WB,   JC_NEVER,    STEP_IDLE,     STEP_RESPOND};
         STEP_DIV_ITER:  word = '{UOP_DIV_STEP, JC_DIV_MORE, STEP_DIV_ITER, STEP_DIV_WB};
         STEP_DIV_WB:    word = '{UOP_DIV_WB,   JC_NEVER,    STEP_IDLE,     STEP_RESPOND};
         STEP_RESPOND:   word = '{UOP_RESPOND,  JC_OUT_BUSY, STEP_RESPOND,  STEP_IDLE};
         default:        word = '{UOP_NONE,     JC_NEVER,    STEP_IDLE,     STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

[rtl/trme_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_req_if
// Request channel: one decoded instruction per transfer.
// ----------------------------------------------------------------------------
interface trme_req_if
   import trme_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [REG_IDX_W-1:0] dest_reg;
   logic                 src_is_imm;
   logic [REG_IDX_W-1:0] src_reg;
   logic [IMM_W-1:0]     immediate;
   logic [TARGET_W-1:0]  jump_target;

   modport source (
      output valid, action, dest_reg, src_is_imm, src_reg, immediate, jump_target,
      input  ready
   );
   modport sink (
      input  valid, action, dest_reg, src_is_imm, src_reg, immediate, jump_target,
      output ready
   );
endinterface

[rtl/trme_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_rsp_if
// Response channel: one result per executed instruction.
// ----------------------------------------------------------------------------
interface trme_rsp_if
   import trme_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [TARGET_W-1:0]      next_pc;
   logic                     print_valid;
   logic signed [DATA_W-1:0] print_value;
   logic [ERR_W-1:0]         error_code;
   logic                     is_halted;

   modport source (
      output valid, next_pc, print_valid, print_value, error_code, is_halted,
      input  ready
   );
   modport sink (
      input  valid, next_pc, print_valid, print_value, error_code, is_halted,
      output ready
   );
endinterface

[rtl/tiny_register_machine_execute.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_register_machine_execute
// Executes decoded instructions on a small register file under control of a
// microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one decoded instruction per transfer; rsp returns exactly one
//   result per instruction, in order: next fetch index, print data, error code
//   and the halt flag.
//   Each instruction walks the microprogram: accept, register read, execute,
//   a multiply check (and the multiply writeback for mul) or, for div, the 32
//   iterations of the restoring divider and the divide writeback, then the
//   result is loaded into the rsp output register. The next instruction is
//   taken while an earlier result still waits in the output register; a
//   stalled rsp holds its result and the sequencer waits in its respond step
//   until the register frees.
//   Reset clears the program counter, the compare latch, the halt flag, all
//   present bits and the rsp valid; the block is ready in the next cycle.
//   After an error every later instruction only reports the halted state.
// ----------------------------------------------------------------------------
module tiny_register_machine_execute
   import trme_pkg::*;
#(
   parameter int unsigned NUM_REGS = 10,
   parameter int unsigned PC_BITS  = 10
) (
   input  logic       clock,
   input  logic       reset,
   trme_req_if.sink   req,
   trme_rsp_if.source rsp
);

   localparam int unsigned IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int unsigned CNT_W = $clog2(DATA_W);
   localparam logic [REG_IDX_W:0] REG_LIMIT = (REG_IDX_W + 1)'(NUM_REGS);
   localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(DATA_W - 1);

   typedef logic [PC_BITS-1:0] pc_count_type;
   typedef logic [IDX_W-1:0]   reg_index_type;
   typedef logic [DATA_W-1:0]  word_type;

   // sequencer
   step_type  upc_ff, upc_in;
   ucode_type ctrl;
   logic      take_jump;

   // latched instruction
   action_type           act_ff;
   logic [REG_IDX_W-1:0] dest_ff, src_ff;
   logic                 imm_sel_ff;
   logic [IMM_W-1:0]     imm_ff;
   logic [TARGET_W-1:0]  target_ff;

   // register file
   word_type      regfile_mem [NUM_REGS];
   word_type      rd_dest_ff, rd_src_ff;
   logic [NUM_REGS-1:0] present_ff, present_in;
   logic [NUM_REGS-1:0] filled_ff, filled_in;
   logic          wr_en;
   word_type      wr_data;

   // architectural state
   pc_count_type pc_ff, pc_in;
   logic         halt_ff, halt_in;
   logic         cmp_pend_ff, cmp_pend_in;
   word_type     cmp_left_ff, cmp_left_in, cmp_right_ff, cmp_right_in;

   // result staging
   logic [TARGET_W-1:0] res_npc_ff, res_npc_in;
   logic                res_pvalid_ff, res_pvalid_in;
   word_type            res_pval_ff, res_pval_in;
   error_type           res_err_ff, res_err_in;
   logic                res_halt_ff;

   // mul / div
   logic                mul_go_ff, mul_go_in;
   logic                div_go;
   word_type            mul_full;
   word_type            mul_ff;
   word_type            div_q_ff, div_q_in, div_r_ff, div_r_in, div_b_ff;
   logic                div_neg_ff;
   logic [CNT_W-1:0]    div_cnt_ff;
   logic [DATA_W:0]     div_shift, div_diff;
   word_type            mag_dest, mag_src;

   // output register
   logic                rsp_valid_ff;
   logic                rsp_load;
   logic [TARGET_W-1:0] rsp_npc_ff;
   logic                rsp_pvalid_ff;
   word_type            rsp_pval_ff;
   error_type           rsp_err_ff;
   logic                rsp_halt_ff;

   // operand decode
   logic          dest_ok, src_ok, dest_present, cond_hold;
   reg_index_type dest_idx, src_idx;
   word_type      dest_val, src_reg_val, src_val;
   pc_count_type  pc_target;
   error_type     err;

   assign dest_idx  = dest_ff[IDX_W-1:0];
   assign src_idx   = src_ff[IDX_W-1:0];
   assign dest_ok   = {1'b0, dest_ff} < REG_LIMIT;
   assign src_ok    = {1'b0, src_ff} < REG_LIMIT;
   assign pc_target = pc_count_type'(target_ff);

   // never-written entries read as zero
   assign dest_val    = (dest_ok && filled_ff[dest_idx]) ? rd_dest_ff : '0;
   assign src_reg_val = (src_ok && filled_ff[src_idx]) ? rd_src_ff : '0;
   assign src_val     = imm_sel_ff ? {1'b0, imm_ff} : src_reg_val;

   // a register source read makes that register present before the check
   assign dest_present = dest_ok &&
                         (present_ff[dest_idx] || (!imm_sel_ff && src_ff == dest_ff));

   assign mul_full = dest_val * src_val;
   assign mag_dest = dest_val[DATA_W-1] ? (~dest_val + 1'b1) : dest_val;
   assign mag_src  = src_val[DATA_W-1] ? (~src_val + 1'b1) : src_val;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign div_shift = {div_r_ff, div_q_ff[DATA_W-1]};
   assign div_diff  = div_shift - {1'b0, div_b_ff};

   always_comb begin
      case (act_ff)
         ACT_JE:  cond_hold = $signed(cmp_left_ff) == $signed(cmp_right_ff);
         ACT_JNE: cond_hold = $signed(cmp_left_ff) != $signed(cmp_right_ff);
         ACT_JG:  cond_hold = $signed(cmp_left_ff) >  $signed(cmp_right_ff);
         ACT_JGE: cond_hold = $signed(cmp_left_ff) >= $signed(cmp_right_ff);
         ACT_JL:  cond_hold = $signed(cmp_left_ff) <  $signed(cmp_right_ff);
         ACT_JLE: cond_hold = $signed(cmp_left_ff) <= $signed(cmp_right_ff);
         default: cond_hold = 1'b0;
      endcase
   end

   // sequencer: fetch control word, resolve branch
   always_comb begin
      ctrl = ucode_rom(upc_ff);
      case (ctrl.cond)
         JC_NEVER:    take_jump = 1'b0;
         JC_NO_REQ:   take_jump = !req.valid;
         JC_TO_DIV:   take_jump = div_go;
         JC_NOT_MUL:  take_jump = !mul_go_ff;
         JC_DIV_MORE: take_jump = div_cnt_ff != CNT_LAST;
         JC_OUT_BUSY: take_jump = rsp_valid_ff && !rsp.ready;
         default:     take_jump = 1'b0;
      endcase
      upc_in = take_jump ? ctrl.jump_to : ctrl.next;
   end

   assign req.ready = (ctrl.uop == UOP_ACCEPT) && !reset;
   assign rsp_load  = (ctrl.uop == UOP_RESPOND) && !(rsp_valid_ff && !rsp.ready);

   // datapath control
   always_comb begin
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      cmp_pend_in  = cmp_pend_ff;
      cmp_left_in  = cmp_left_ff;
      cmp_right_in = cmp_right_ff;
      present_in   = present_ff;
      filled_in    = filled_ff;
      wr_en        = 1'b0;
      wr_data      = mul_ff;
      mul_go_in    = 1'b0;
      div_go       = 1'b0;
      err          = ERR_NONE;
      res_npc_in   = TARGET_W'(pc_ff);
      res_pvalid_in = 1'b0;
      res_pval_in  = '0;
      res_err_in   = ERR_NONE;

      case (ctrl.uop)
         UOP_EXEC: begin
            pc_in = pc_ff + 1'b1;
            if (halt_ff) begin
               pc_in = pc_ff;
            end else if (cmp_pend_ff) begin
               cmp_pend_in = 1'b0;
               if (cond_hold) begin
                  pc_in = pc_target;
               end
            end else begin
               case (act_ff)
                  ACT_MOV, ACT_ADD, ACT_SUB, ACT_AND, ACT_OR, ACT_DIV, ACT_MUL: begin
                     if (!imm_sel_ff && src_ok) begin
                        present_in[src_idx] = 1'b1;
                     end
                     if (act_ff == ACT_MOV) begin
                        wr_en   = dest_ok;
                        wr_data = src_val;
                     end else if (!dest_present) begin
                        err = ERR_ABSENT_ARITH;
                     end else if (act_ff == ACT_DIV && src_val == '0) begin
                        err = ERR_DIV_ZERO;
                     end else begin
                        case (act_ff)
                           ACT_ADD: begin
                              wr_en   = 1'b1;
                              wr_data = dest_val + src_val;
                           end
                           ACT_SUB: begin
                              wr_en   = 1'b1;
                              wr_data = dest_val - src_val;
                           end
                           ACT_AND: begin
                              wr_en   = 1'b1;
                              wr_data = dest_val & src_val;
                           end
                           ACT_OR: begin
                              wr_en   = 1'b1;
                              wr_data = dest_val | src_val;
                           end
                           ACT_DIV: div_go    = 1'b1;
                           default: mul_go_in = 1'b1;
                        endcase
                     end
                  end
                  ACT_INC, ACT_DEC: begin
                     wr_en   = dest_ok;
                     wr_data = (act_ff == ACT_INC) ? dest_val + 1'b1 : dest_val - 1'b1;
                  end
                  ACT_PRINT: begin
                     if (dest_ok && present_ff[dest_idx]) begin
                        res_pvalid_in = 1'b1;
                        res_pval_in   = dest_val;
                     end else begin
                        err = ERR_ABSENT_PRINT;
                     end
                  end
                  ACT_CMP: begin
                     cmp_left_in  = dest_val;
                     cmp_right_in = src_reg_val;
                     cmp_pend_in  = 1'b1;
                     if (dest_ok) begin
                        present_in[dest_idx] = 1'b1;
                     end
                     if (src_ok) begin
                        present_in[src_idx] = 1'b1;
                     end
                  end
                  ACT_JMP: pc_in = pc_target;
                  default: ;
               endcase
            end
            if (err != ERR_NONE) begin
               halt_in = 1'b1;
               pc_in   = pc_ff;
            end
            res_npc_in = TARGET_W'(pc_in);
            res_err_in = err;
         end
         UOP_MUL_WB: begin
            wr_en   = 1'b1;
            wr_data = mul_ff;
         end
         UOP_DIV_WB: begin
            wr_en   = 1'b1;
            wr_data = div_neg_ff ? (~div_q_ff + 1'b1) : div_q_ff;
         end
         default: ;
      endcase

      if (wr_en) begin
         present_in[dest_idx] = 1'b1;
         filled_in[dest_idx]  = 1'b1;
      end
   end

   always_comb begin
      if (div_diff[DATA_W]) begin
         div_r_in = div_shift[DATA_W-1:0];
         div_q_in = {div_q_ff[DATA_W-2:0], 1'b0};
      end else begin
         div_r_in = div_diff[DATA_W-1:0];
         div_q_in = {div_q_ff[DATA_W-2:0], 1'b1};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= STEP_IDLE;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         cmp_pend_ff  <= 1'b0;
         cmp_left_ff  <= '0;
         cmp_right_ff <= '0;
         present_ff   <= '0;
         filled_ff    <= '0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         cmp_pend_ff  <= cmp_pend_in;
         cmp_left_ff  <= cmp_left_in;
         cmp_right_ff <= cmp_right_in;
         present_ff   <= present_in;
         filled_ff    <= filled_in;
         if (ctrl.uop == UOP_EXEC) begin
            mul_go_ff <= mul_go_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         regfile_mem[dest_idx] <= wr_data;
      end
      if (ctrl.uop == UOP_READ) begin
         rd_dest_ff <= regfile_mem[dest_idx];
         rd_src_ff  <= regfile_mem[src_idx];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         act_ff     <= action_type'(req.action);
         dest_ff    <= req.dest_reg;
         imm_sel_ff <= req.src_is_imm;
         src_ff     <= req.src_reg;
         imm_ff     <= req.immediate;
         target_ff  <= req.jump_target;
      end
      if (ctrl.uop == UOP_EXEC) begin
         res_npc_ff    <= res_npc_in;
         res_pvalid_ff <= res_pvalid_in;
         res_pval_ff   <= res_pval_in;
         res_err_ff    <= res_err_in;
         res_halt_ff   <= halt_in;
         mul_ff        <= mul_full;
         div_q_ff      <= mag_dest;
         div_r_ff      <= '0;
         div_b_ff      <= mag_src;
         div_neg_ff    <= dest_val[DATA_W-1] ^ src_val[DATA_W-1];
         div_cnt_ff    <= '0;
      end else if (ctrl.uop == UOP_DIV_STEP) begin
         div_q_ff   <= div_q_in;
         div_r_ff   <= div_r_in;
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (rsp_load) begin
         rsp_npc_ff    <= res_npc_ff;
         rsp_pvalid_ff <= res_pvalid_ff;
         rsp_pval_ff   <= res_pval_ff;
         rsp_err_ff    <= res_err_ff;
         rsp_halt_ff   <= res_halt_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.next_pc     = rsp_npc_ff;
   assign rsp.print_valid = rsp_pvalid_ff;
   assign rsp.print_value = rsp_pval_ff;
   assign rsp.error_code  = rsp_err_ff;
   assign rsp.is_halted   = rsp_halt_ff;

endmodule

[rtl/trme_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_checker
// Port-level checks of the execute block, bound to the top level.
// ----------------------------------------------------------------------------
module trme_checker
   import trme_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [TARGET_W-1:0]  rsp_next_pc,
   input logic                 rsp_print_valid,
   input logic [DATA_W-1:0]    rsp_print_value,
   input logic [ERR_W-1:0]     rsp_error_code,
   input logic                 rsp_is_halted
);

   // a stalled result stays valid and keeps its next_pc
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc))
      else $error("trme: stalled response changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("trme: response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> rsp_is_halted)
      else $error("trme: error without halt");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_print_valid |-> rsp_error_code == ERR_NONE && !rsp_is_halted)
      else $error("trme: print on a failing or halted instruction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_print_valid |-> rsp_print_value == '0)
      else $error("trme: print value without print");

endmodule

bind tiny_register_machine_execute trme_checker u_trme_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_next_pc     (rsp.next_pc),
   .rsp_print_valid (rsp.print_valid),
   .rsp_print_value (rsp.print_value),
   .rsp_error_code  (rsp.error_code),
   .rsp_is_halted   (rsp.is_halted)
);
